// ===== rtl/core/bmp16_pkg.sv =====
package bmp16_pkg;

    // register map, index = paddr / 4
    localparam logic [2:0] REG_RED_MASK     = 3'd0;
    localparam logic [2:0] REG_GREEN_MASK   = 3'd1;
    localparam logic [2:0] REG_BLUE_MASK    = 3'd2;
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd3;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd4;
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd5;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd6;

    localparam int unsigned DIM_W       = 11;
    localparam int unsigned PIX_W       = 16;
    localparam int unsigned ADDR_W      = 21;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [4:0] RED_BITS   = 5'd5;
    localparam logic [4:0] GREEN_BITS = 5'd6;
    localparam logic [4:0] BLUE_BITS  = 5'd5;

    // per-channel shift setup, derived from the mask
    typedef struct packed {
        logic [3:0] low_zeros;
        logic       left;
        logic [3:0] amount;
    } chan_cfg_t;

    typedef struct packed {
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
        logic [DIM_W-1:0] frame_width;
        logic [DIM_W-1:0] frame_height;
    } geom_t;

    typedef struct packed {
        logic [PIX_W-1:0] red_mask;
        logic [PIX_W-1:0] green_mask;
        logic [PIX_W-1:0] blue_mask;
        chan_cfg_t        red_cfg;
        chan_cfg_t        green_cfg;
        chan_cfg_t        blue_cfg;
    } colour_cfg_t;

    // one classified word between front and back
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
        logic             write_enable;
        logic             last_pixel;
        logic             size_error;
    } front_item_t;

    function automatic chan_cfg_t derive_chan(input logic [PIX_W-1:0] mask,
                                              input logic [4:0] target);
        logic [4:0] ones;
        logic [3:0] lz;
        logic       found;
        chan_cfg_t  c;
        ones  = '0;
        lz    = '0;
        found = 1'b0;
        for (int i = 0; i < PIX_W; i++) begin
            ones = ones + 5'(mask[i]);
            if (mask[i] && !found) begin
                lz    = 4'(i);
                found = 1'b1;
            end
        end
        c.low_zeros = lz;
        if (ones <= target) begin
            c.left   = 1'b1;
            c.amount = 4'(target - ones);
        end
        else begin
            c.left   = 1'b0;
            c.amount = 4'(ones - target);
        end
        return c;
    endfunction

    // result is cut to the channel width by the caller
    function automatic logic [5:0] convert_chan(input logic [PIX_W-1:0] pixel,
                                                input logic [PIX_W-1:0] mask,
                                                input chan_cfg_t c);
        logic [PIX_W-1:0] ext;
        logic [PIX_W-1:0] sh;
        ext = (pixel & mask) >> c.low_zeros;
        if (c.left)
            sh = ext << c.amount;
        else
            sh = ext >> c.amount;
        return sh[5:0];
    endfunction

endpackage

// ===== rtl/core/bmp16_front.sv =====
module bmp16_front
    import bmp16_pkg::*;
#(
    parameter int unsigned MAX_DIMENSION = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  geom_t            geom,
    input  logic             word_valid,
    output logic             word_ready,
    input  logic [PIX_W-1:0] word_data,
    output logic             push,
    output front_item_t      push_item,
    input  logic             queue_full
);

    logic [DIM_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] row_reg, row_next;
    logic             size_err;
    logic [DIM_W:0]   row_words;
    logic             out_of_range;
    logic [DIM_W-1:0] col_cur, row_cur;
    logic [DIM_W:0]   col_inc;
    logic [DIM_W:0]   row_inc;
    logic             is_pixel;
    logic [DIM_W-1:0] src_y;
    logic [DIM_W-1:0] row_base, col_base;

    assign word_ready = !queue_full;
    assign push       = word_valid && word_ready;

    always_comb
    begin
        size_err = (geom.image_width == '0) || (geom.image_height == '0) ||
                   (geom.image_width > geom.frame_width) ||
                   (geom.image_height > geom.frame_height) ||
                   (32'(geom.frame_width) > MAX_DIMENSION) ||
                   (32'(geom.frame_height) > MAX_DIMENSION);

        row_words    = {1'b0, geom.image_width} + (DIM_W+1)'(geom.image_width[0]);
        out_of_range = ({1'b0, col_reg} >= row_words) || (row_reg >= geom.image_height);
        col_cur      = out_of_range ? '0 : col_reg;
        row_cur      = out_of_range ? '0 : row_reg;
        is_pixel     = col_cur < geom.image_width;

        src_y    = geom.image_height - 1'b1 - row_cur;
        row_base = (geom.frame_height - geom.image_height) >> 1;
        col_base = (geom.frame_width - geom.image_width) >> 1;

        push_item.pixel        = word_data;
        push_item.row          = row_base + src_y;
        push_item.col          = col_base + col_cur;
        push_item.write_enable = !size_err && is_pixel;
        push_item.last_pixel   = !size_err && is_pixel &&
                                 (row_cur == geom.image_height - 1'b1) &&
                                 (col_cur == geom.image_width - 1'b1);
        push_item.size_error   = size_err;

        col_inc  = {1'b0, col_cur} + 1'b1;
        row_inc  = {1'b0, row_cur} + 1'b1;
        col_next = col_reg;
        row_next = row_reg;
        if (push) begin
            if (size_err) begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_inc >= row_words) begin
                col_next = '0;
                row_next = (row_inc >= {1'b0, geom.image_height}) ? '0 : row_inc[DIM_W-1:0];
            end
            else begin
                col_next = col_inc[DIM_W-1:0];
                row_next = row_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== rtl/core/bmp16_queue.sv =====
module bmp16_queue
    import bmp16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  front_item_t push_item,
    output logic        full,
    input  logic        pop,
    output front_item_t pop_item,
    output logic        not_empty
);

    front_item_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;

    assign full      = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/bmp16_back.sv =====
module bmp16_back
    import bmp16_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [DIM_W-1:0]  frame_width,
    input  colour_cfg_t       colour,
    input  logic              item_valid,
    input  front_item_t       item,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [PIX_W-1:0]  rgb565,
    output logic [ADDR_W-1:0] byte_address,
    output logic              write_enable,
    output logic              last_pixel,
    output logic              size_error
);

    logic              valid_reg, valid_next;
    logic [PIX_W-1:0]  rgb_reg, rgb_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              we_reg, last_reg, err_reg;
    logic [2*DIM_W-1:0] product;
    logic [2*DIM_W:0]   linear;
    logic [5:0]        red6, green6, blue6;

    assign pop = item_valid && (!valid_reg || out_ready);

    always_comb
    begin
        red6    = convert_chan(item.pixel, colour.red_mask, colour.red_cfg);
        green6  = convert_chan(item.pixel, colour.green_mask, colour.green_cfg);
        blue6   = convert_chan(item.pixel, colour.blue_mask, colour.blue_cfg);
        product = item.row * frame_width;
        linear  = {1'b0, product} + (2*DIM_W+1)'(item.col);

        rgb_next  = item.write_enable ? {red6[4:0], green6, blue6[4:0]} : '0;
        addr_next = item.write_enable ? {linear[ADDR_W-2:0], 1'b0} : '0;

        if (pop)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            rgb_reg  <= rgb_next;
            addr_reg <= addr_next;
            we_reg   <= item.write_enable;
            last_reg <= item.last_pixel;
            err_reg  <= item.size_error;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    assign out_valid    = valid_reg;
    assign rgb565       = rgb_reg;
    assign byte_address = addr_reg;
    assign write_enable = we_reg;
    assign last_pixel   = last_reg;
    assign size_error   = err_reg;

endmodule

// ===== rtl/core/bmp16_to_rgb565_placer.sv =====
// Streams the 16-bit words of a BMP pixel array, in file order (bottom row
// first), and turns each one into an RGB565 pixel plus the frame buffer
// byte address of its place: the image is centred in the frame and flipped
// so the top row lands at the lowest address. On odd widths the padding
// word at the end of each row is consumed and answered with write_enable
// low and zero payload. Each channel is pulled out under its mask (APB
// registers at 0x00/0x04/0x08, reset to 5-5-5), shifted down and rescaled
// to 5/6/5 bits; a zero mask gives zero. Image and frame sizes sit at
// 0x0C..0x18. If the sizes are invalid (zero, image larger than frame, or
// frame above MAX_DIMENSION) every word returns size_error with zero
// payload and the position counters clear. tlast marks the final pixel of
// the image. Throughput is one word per clock while m_axis_tready is high;
// the front classifies each accepted word into a four-deep queue, then
// the back end's single stage holding the 11x11 address multiply and the
// channel shifters registers it and presents the result. The derived
// shift registers follow a mask change in the next cycle. Write
// configuration only while idle.
module bmp16_to_rgb565_placer
    import bmp16_pkg::*;
#(
    parameter int unsigned MAX_DIMENSION = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // source words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] source_word
    // placed pixels
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [15:0] rgb565, [36:16] byte_address, zero above
    output logic [1:0]  m_axis_tuser,   // [0] write_enable, [1] size_error
    output logic        m_axis_tlast    // last_pixel
);

    logic [PIX_W-1:0] red_mask_reg, green_mask_reg, blue_mask_reg;
    logic [DIM_W-1:0] image_width_reg, image_height_reg;
    logic [DIM_W-1:0] frame_width_reg, frame_height_reg;
    chan_cfg_t        red_cfg_reg, green_cfg_reg, blue_cfg_reg;
    logic             cfg_write;
    logic [2:0]       reg_index;

    geom_t            geom;
    colour_cfg_t      colour;

    logic             push, queue_full, pop, queue_valid;
    front_item_t      push_item, pop_item;

    logic [PIX_W-1:0]  rgb565;
    logic [ADDR_W-1:0] byte_address;
    logic              write_enable, size_error;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            red_mask_reg     <= 16'h7C00;
            green_mask_reg   <= 16'h03E0;
            blue_mask_reg    <= 16'h001F;
            image_width_reg  <= 11'd1;
            image_height_reg <= 11'd1;
            frame_width_reg  <= 11'd1024;
            frame_height_reg <= 11'd1024;
        end
        else if (cfg_write) begin
            unique case (reg_index)
                REG_RED_MASK:     red_mask_reg     <= pwdata[PIX_W-1:0];
                REG_GREEN_MASK:   green_mask_reg   <= pwdata[PIX_W-1:0];
                REG_BLUE_MASK:    blue_mask_reg    <= pwdata[PIX_W-1:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[DIM_W-1:0];
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[DIM_W-1:0];
                default:          ;
            endcase
        end
    end

    // shift setup is registered from the masks in the next cycle (popcount, trailing zeros)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            red_cfg_reg   <= derive_chan(16'h7C00, RED_BITS);
            green_cfg_reg <= derive_chan(16'h03E0, GREEN_BITS);
            blue_cfg_reg  <= derive_chan(16'h001F, BLUE_BITS);
        end
        else begin
            red_cfg_reg   <= derive_chan(red_mask_reg, RED_BITS);
            green_cfg_reg <= derive_chan(green_mask_reg, GREEN_BITS);
            blue_cfg_reg  <= derive_chan(blue_mask_reg, BLUE_BITS);
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_RED_MASK:     prdata = 32'(red_mask_reg);
            REG_GREEN_MASK:   prdata = 32'(green_mask_reg);
            REG_BLUE_MASK:    prdata = 32'(blue_mask_reg);
            REG_IMAGE_WIDTH:  prdata = 32'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = 32'(image_height_reg);
            REG_FRAME_WIDTH:  prdata = 32'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = 32'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    assign geom.image_width  = image_width_reg;
    assign geom.image_height = image_height_reg;
    assign geom.frame_width  = frame_width_reg;
    assign geom.frame_height = frame_height_reg;

    assign colour.red_mask   = red_mask_reg;
    assign colour.green_mask = green_mask_reg;
    assign colour.blue_mask  = blue_mask_reg;
    assign colour.red_cfg    = red_cfg_reg;
    assign colour.green_cfg  = green_cfg_reg;
    assign colour.blue_cfg   = blue_cfg_reg;

    // ---------------- front: position tracking and classification ----------------
    bmp16_front #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .geom       (geom),
        .word_valid (s_axis_tvalid),
        .word_ready (s_axis_tready),
        .word_data  (s_axis_tdata),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    // ---------------- decoupling queue ----------------
    bmp16_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .not_empty (queue_valid)
    );

    // ---------------- back: colour conversion and address ----------------
    bmp16_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (frame_width_reg),
        .colour       (colour),
        .item_valid   (queue_valid),
        .item         (pop_item),
        .pop          (pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .rgb565       (rgb565),
        .byte_address (byte_address),
        .write_enable (write_enable),
        .last_pixel   (m_axis_tlast),
        .size_error   (size_error)
    );

    assign m_axis_tdata = {3'b000, byte_address, rgb565};
    assign m_axis_tuser = {size_error, write_enable};

endmodule
